@@ design/imm_pkg.sv @@
// ----------------------------------------------------------------------------
// imm_pkg: shared types and constants for the integer matrix multiplier
// Holds the field widths, command and register codes, sequencer states,
// the tag that travels beside the multiply-accumulate pipeline, and the
// helper that turns a dimension register into its effective value.
// ----------------------------------------------------------------------------
package imm_pkg;

    localparam int MAX_DIM_DEF = 16;    // default edge length of each store
    localparam int DIM_LIMIT   = 16;    // largest dimension the 4-bit indexes reach
    localparam int IDX_W       = 4;     // row and column index fields
    localparam int DATA_W      = 32;    // element and result width
    localparam int CFG_W       = 5;     // dimension register width
    localparam int CMD_W       = 2;
    localparam int REG_IDX_W   = 2;
    localparam int S_DATA_W    = 40;    // row, col, value
    localparam int M_DATA_W    = 40;    // out_row, out_col, c_value

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } cmd_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_COLS_B    = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_DRAIN
    } seq_state_t;

    // Control that rides along with each multiply-accumulate step.
    typedef struct packed {
        logic             valid;
        logic             first;    // first term of a dot product
        logic             last_k;   // final term of a dot product
        logic             last_j;   // final column of the row
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } mac_tag_t;

    // One finished element of C.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
    } mac_result_t;

    // Zero acts as one; anything above the cap saturates at the cap.
    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] raw,
                                                 input logic [CFG_W-1:0] cap);
        logic [CFG_W-1:0] res;
        if (raw == '0)
        begin
            res = CFG_W'(1);
        end
        else if (raw > cap)
        begin
            res = cap;
        end
        else
        begin
            res = raw;
        end
        return res;
    endfunction

endpackage

@@ design/imm_mem.sv @@
// ----------------------------------------------------------------------------
// imm_mem: element store
// One write port and one read port; read data is registered and holds
// while the read enable is low.
// ----------------------------------------------------------------------------
module imm_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [imm_pkg::DATA_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [imm_pkg::DATA_W-1:0] rd_data
);
    import imm_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/imm_mac.sv @@
// ----------------------------------------------------------------------------
// imm_mac: shared multiply-accumulate unit
// Aligns the issue tag with the store read data, registers the 32-bit
// product, then accumulates it. The whole pipeline holds when adv is low.
// ----------------------------------------------------------------------------
module imm_mac (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  imm_pkg::mac_tag_t          tag_in,
    input  logic [imm_pkg::DATA_W-1:0] a_data,
    input  logic [imm_pkg::DATA_W-1:0] b_data,
    output logic                       busy,
    output imm_pkg::mac_result_t       result
);
    import imm_pkg::*;

    mac_tag_t          tag1_reg;
    mac_tag_t          tag2_reg;
    mac_tag_t          tag3_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] prod_lo;

    // Only the low word is kept, which is the same for signed and unsigned.
    assign prod_lo = a_data * b_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else if (adv)
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_lo;
            if (tag2_reg.valid)
            begin
                acc_reg <= tag2_reg.first ? prod_reg : acc_reg + prod_reg;
            end
        end
    end

    assign busy = tag1_reg.valid | tag2_reg.valid | tag3_reg.valid;

    always_comb
    begin
        result.valid = tag3_reg.valid & tag3_reg.last_k;
        result.last  = tag3_reg.last_j;
        result.row   = tag3_reg.row;
        result.col   = tag3_reg.col;
        result.value = acc_reg;
    end

endmodule

@@ design/imm_seq.sv @@
// ----------------------------------------------------------------------------
// imm_seq: command sequencer
// Takes load and compute beats while idle, writes loads into the stores,
// and walks the column and inner-dimension counters of a row compute.
// ----------------------------------------------------------------------------
module imm_seq #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [imm_pkg::CMD_W-1:0]     cmd,
    input  logic [imm_pkg::IDX_W-1:0]     row_in,
    input  logic [imm_pkg::IDX_W-1:0]     col_in,
    input  logic [imm_pkg::DATA_W-1:0]    value_in,
    input  logic [imm_pkg::CFG_W-1:0]     m_eff,
    input  logic [imm_pkg::CFG_W-1:0]     kd_eff,
    input  logic [imm_pkg::CFG_W-1:0]     n_eff,
    input  logic                          adv,
    input  logic                          pipe_busy,
    output logic                          a_wr_en,
    output logic                          b_wr_en,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr,
    output logic [imm_pkg::DATA_W-1:0]    wr_data,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] a_rd_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] b_rd_addr,
    output imm_pkg::mac_tag_t             tag
);
    import imm_pkg::*;

    localparam int DIM_CAP = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;
    localparam int CNT_W   = $clog2(DIM_CAP);
    localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             k_done;
    logic             j_done;
    logic             row_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            row_reg   <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    assign k_done = (CFG_W'(k_reg) + CFG_W'(1)) == kd_eff;
    assign j_done = (CFG_W'(j_reg) + CFG_W'(1)) == n_eff;
    assign row_ok = CFG_W'(row_in) < m_eff;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        a_wr_en    = 1'b0;
        b_wr_en    = 1'b0;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (cmd_t'(cmd))
                        CMD_LOAD_A:
                        begin
                            a_wr_en = row_ok && (CFG_W'(col_in) < kd_eff);
                        end
                        CMD_LOAD_B:
                        begin
                            b_wr_en = (CFG_W'(row_in) < kd_eff) && (CFG_W'(col_in) < n_eff);
                        end
                        CMD_COMPUTE:
                        begin
                            if (row_ok)
                            begin
                                state_next = SEQ_RUN;
                                row_next   = CNT_W'(row_in);
                                j_next     = '0;
                                k_next     = '0;
                            end
                        end
                        default:
                        begin
                            state_next = SEQ_IDLE;
                        end
                    endcase
                end
            end
            SEQ_RUN:
            begin
                if (adv)
                begin
                    if (k_done)
                    begin
                        k_next = '0;
                        if (j_done)
                        begin
                            state_next = SEQ_DRAIN;
                        end
                        else
                        begin
                            j_next = j_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        k_next = k_reg + CNT_W'(1);
                    end
                end
            end
            SEQ_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == SEQ_IDLE);

    assign wr_addr   = ADDR_W'(ADDR_W'(row_in) * ADDR_W'(MAX_DIM)) + ADDR_W'(col_in);
    assign wr_data   = value_in;
    assign a_rd_addr = ADDR_W'(ADDR_W'(row_reg) * ADDR_W'(MAX_DIM)) + ADDR_W'(k_reg);
    assign b_rd_addr = ADDR_W'(ADDR_W'(k_reg) * ADDR_W'(MAX_DIM)) + ADDR_W'(j_reg);

    always_comb
    begin
        tag.valid  = (state_reg == SEQ_RUN);
        tag.first  = (k_reg == '0);
        tag.last_k = k_done;
        tag.last_j = j_done;
        tag.row    = IDX_W'(row_reg);
        tag.col    = IDX_W'(j_reg);
    end

endmodule

@@ design/int_matrix_multiply.sv @@
// ----------------------------------------------------------------------------
// int_matrix_multiply: integer matrix product C = A x B
// Loads elements of A and B into two on-chip stores and, on request,
// streams one row of C through a shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries commands. s_tuser holds the command (load an
// element of A, load an element of B, or compute one row of C) and s_tdata
// holds the row, the column and the 32-bit element value. A load beat leaves
// the block idle and ready; loads that fall outside the configured
// dimensions are dropped, as are unused commands.
// A compute beat for row i walks cols_b output columns, each as inner_dim
// multiply-accumulate steps on the single shared multiplier, one step per
// cycle with one read of each store while the pipeline is not stalled. The
// block stays busy while the steps issue and while the read, multiply and
// accumulate stages drain; s_tready is low then.
// Each element leaves on the master stream as one beat, with tlast on the
// final column. A stalled beat holds in the output register; when the next
// element finishes, the pipeline freezes until the held beat is taken.
// The configuration channel writes rows_a, inner_dim and cols_b; it is
// always ready and is meant to be used while the block is idle.
// Reset sets all three dimensions to 16 and leaves the stores unwritten.
// ----------------------------------------------------------------------------
module int_matrix_multiply #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Command stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [imm_pkg::S_DATA_W-1:0] s_tdata,   // row[3:0], col[7:4], value[39:8]
    input  logic [imm_pkg::CMD_W-1:0]    s_tuser,   // command[1:0]
    // Result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [imm_pkg::M_DATA_W-1:0] m_tdata,   // out_row[3:0], out_col[7:4],
                                                    // c_value[39:8]
    output logic                         m_tlast,
    // Configuration writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [imm_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]    cfg_data
);
    import imm_pkg::*;

    localparam int DIM_CAP = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);

    // Dimension registers, raw as written.
    logic [CFG_W-1:0] rows_a_reg;
    logic [CFG_W-1:0] inner_dim_reg;
    logic [CFG_W-1:0] cols_b_reg;

    logic [CFG_W-1:0] m_eff;
    logic [CFG_W-1:0] kd_eff;
    logic [CFG_W-1:0] n_eff;

    logic              a_wr_en;
    logic              b_wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0] a_rd_addr;
    logic [ADDR_W-1:0] b_rd_addr;
    logic [DATA_W-1:0] a_rd_data;
    logic [DATA_W-1:0] b_rd_data;
    mac_tag_t          issue_tag;
    mac_result_t       mac_res;
    logic              pipe_busy;
    logic              adv;

    // Output register.
    logic              out_valid_reg;
    logic              out_last_reg;
    logic [IDX_W-1:0]  out_row_reg;
    logic [IDX_W-1:0]  out_col_reg;
    logic [DATA_W-1:0] out_value_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= CFG_RESET;
            inner_dim_reg <= CFG_RESET;
            cols_b_reg    <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ROWS_A:    rows_a_reg    <= cfg_data;
                REG_INNER_DIM: inner_dim_reg <= cfg_data;
                REG_COLS_B:    cols_b_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign m_eff  = eff_dim(rows_a_reg, CFG_W'(DIM_CAP));
    assign kd_eff = eff_dim(inner_dim_reg, CFG_W'(DIM_CAP));
    assign n_eff  = eff_dim(cols_b_reg, CFG_W'(DIM_CAP));

    // The pipeline only stops when a finished element has nowhere to go.
    assign adv = !(mac_res.valid && out_valid_reg && !m_tready);

    imm_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cmd       (s_tuser),
        .row_in    (s_tdata[IDX_W-1:0]),
        .col_in    (s_tdata[2*IDX_W-1:IDX_W]),
        .value_in  (s_tdata[2*IDX_W+DATA_W-1:2*IDX_W]),
        .m_eff     (m_eff),
        .kd_eff    (kd_eff),
        .n_eff     (n_eff),
        .adv       (adv),
        .pipe_busy (pipe_busy),
        .a_wr_en   (a_wr_en),
        .b_wr_en   (b_wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .a_rd_addr (a_rd_addr),
        .b_rd_addr (b_rd_addr),
        .tag       (issue_tag)
    );

    imm_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem_a (
        .clk     (clk),
        .wr_en   (a_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (adv),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    imm_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem_b (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (adv),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    imm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .tag_in (issue_tag),
        .a_data (a_rd_data),
        .b_data (b_rd_data),
        .busy   (pipe_busy),
        .result (mac_res)
    );

    // A finished element enters the output register whenever the pipeline
    // moves; otherwise the register empties once its beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (mac_res.valid && adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mac_res.valid && adv)
        begin
            out_last_reg  <= mac_res.last;
            out_row_reg   <= mac_res.row;
            out_col_reg   <= mac_res.col;
            out_value_reg <= mac_res.value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_value_reg, out_col_reg, out_row_reg};

endmodule

@@ design/imm_checker.sv @@
// ----------------------------------------------------------------------------
// imm_checker: port-level checks for the integer matrix multiplier
// Watches the command and result streams and is bound to the top level.
// ----------------------------------------------------------------------------
module imm_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [imm_pkg::CMD_W-1:0]    s_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [imm_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                         m_tlast
);
    import imm_pkg::*;

    // A stalled result beat holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // A load leaves the block ready in the cycle after it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_LOAD_A || s_tuser == CMD_LOAD_B)
        |=> s_tready)
        else $error("block not ready after a load");

    // Results only appear while a row compute is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result beat appeared while idle");

    // While a row still has elements to come, no command is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |-> !s_tready)
        else $error("ready while a row is unfinished");

endmodule

bind int_matrix_multiply imm_checker u_imm_checker (.*);
